// File: rtl/itora_pkg.sv
// Shared constants, types, microcode program and digit encoding for the radix ASCII converter.
package itora_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int ND_W        = $clog2(VALUE_WIDTH + 1);
    localparam int PC_W        = 4;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;

    localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
    localparam logic [RADIX_W-1:0] SIGNED_RADIX = 6'd10;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV_INIT  = 4'd2;
    localparam logic [PC_W-1:0] PC_DIV_STEP  = 4'd3;
    localparam logic [PC_W-1:0] PC_PUSH      = 4'd4;
    localparam logic [PC_W-1:0] PC_SIGN_TEST = 4'd5;
    localparam logic [PC_W-1:0] PC_SIGN      = 4'd6;
    localparam logic [PC_W-1:0] PC_POP_TEST  = 4'd7;
    localparam logic [PC_W-1:0] PC_POP       = 4'd8;
    localparam logic [PC_W-1:0] PC_TERM      = 4'd9;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_PUSH,
        OP_EMIT_SIGN,
        OP_EMIT_DIGIT,
        OP_EMIT_TERM
    } op_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_RADIX_BAD,
        CND_DIV_MORE,
        CND_MORE_DIGITS,
        CND_NOT_SIGNED,
        CND_NO_DIGITS
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
    } div_ctrl_t;

    // The control store: a step runs its operation, then jumps to target when its
    // condition holds and otherwise falls through to the next address.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t uw;
        case (pc)
            PC_IDLE:      uw = '{OP_ACCEPT,     CND_NEVER,       PC_IDLE};
            PC_CHECK:     uw = '{OP_NOP,        CND_RADIX_BAD,   PC_TERM};
            PC_DIV_INIT:  uw = '{OP_DIV_INIT,   CND_NEVER,       PC_IDLE};
            PC_DIV_STEP:  uw = '{OP_DIV_STEP,   CND_DIV_MORE,    PC_DIV_STEP};
            PC_PUSH:      uw = '{OP_PUSH,       CND_MORE_DIGITS, PC_DIV_INIT};
            PC_SIGN_TEST: uw = '{OP_NOP,        CND_NOT_SIGNED,  PC_POP_TEST};
            PC_SIGN:      uw = '{OP_EMIT_SIGN,  CND_NEVER,       PC_IDLE};
            PC_POP_TEST:  uw = '{OP_NOP,        CND_NO_DIGITS,   PC_TERM};
            PC_POP:       uw = '{OP_EMIT_DIGIT, CND_ALWAYS,      PC_POP_TEST};
            PC_TERM:      uw = '{OP_EMIT_TERM,  CND_ALWAYS,      PC_IDLE};
            default:      uw = '{OP_NOP,        CND_ALWAYS,      PC_IDLE};
        endcase
        return uw;
    endfunction

    // Digits 0 to 9 map to '0'..'9', 10 to 35 map to 'a'..'z'.
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d < 6'd10) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_A + {2'b00, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: rtl/integer_to_radix_ascii_top.sv
// Top level of the integer to radix ASCII converter: microcode sequencer, digit stack, output register.
//
//  channel | direction | tdata (low bit first)              | tlast
//  s_      | in        | number[31:0], radix[37:32], 0 pad  | -
//  m_      | out       | character[7:0]                     | last (on NUL)
//
// Each digit costs one divider set-up step, bit-serial divide steps and one push,
// then two steps on the way out. An item also runs the accept, check, sign test, final
// pop test and terminator steps, and a minus sign has its own step; a radix out of
// range goes from the check straight to the terminator.
// aresetn, synchronous and active low, returns the program counter to the idle step and
// empties the output register. A stalled m_ channel holds the sequencer at its emit step.
module integer_to_radix_ascii_top
    import itora_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // number[31:0], radix[37:32], zero pad[39:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character[7:0]
    output logic        m_tlast
);

    logic [PC_W-1:0]        pc_reg, pc_next;
    logic                   neg_reg, neg_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [ND_W-1:0]        nd_reg, nd_next;
    logic [DIGIT_W-1:0]     digits_reg [VALUE_WIDTH];
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    uword_t                 uw;
    logic                   out_free;
    logic                   go;
    logic                   cond_true;
    logic                   is_emit;
    logic [VALUE_WIDTH-1:0] in_value;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [RADIX_W-1:0]     in_radix;
    logic [ND_W-1:0]        nd_m1;
    div_ctrl_t              div_ctrl;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
    logic                   div_more;

    assign uw       = ucode(pc_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_radix = s_tdata[37:32];
    // Two's complement magnitude; the most negative value wraps onto its exact magnitude.
    assign in_mag   = in_value[VALUE_WIDTH-1] ? (~in_value + VALUE_WIDTH'(1)) : in_value;
    assign nd_m1    = nd_reg - ND_W'(1);
    assign is_emit  = (uw.op == OP_EMIT_SIGN) || (uw.op == OP_EMIT_DIGIT)
                   || (uw.op == OP_EMIT_TERM);

    // A step runs when its resource is ready: an input transfer for the accept step,
    // room in the output register for the emit steps.
    always_comb begin
        case (uw.op)
            OP_ACCEPT:     go = s_tvalid;
            OP_EMIT_SIGN:  go = out_free;
            OP_EMIT_DIGIT: go = out_free;
            OP_EMIT_TERM:  go = out_free;
            default:       go = 1'b1;
        endcase
    end

    always_comb begin
        case (uw.cond)
            CND_NEVER:       cond_true = 1'b0;
            CND_ALWAYS:      cond_true = 1'b1;
            CND_RADIX_BAD:   cond_true = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
            CND_DIV_MORE:    cond_true = div_more;
            CND_MORE_DIGITS: cond_true = quotient != '0;
            CND_NOT_SIGNED:  cond_true = !(neg_reg && (radix_reg == SIGNED_RADIX));
            CND_NO_DIGITS:   cond_true = nd_reg == '0;
            default:         cond_true = 1'b0;
        endcase
    end

    assign s_tready      = uw.op == OP_ACCEPT;
    assign div_ctrl.load = (uw.op == OP_ACCEPT) && s_tvalid;
    assign div_ctrl.init = uw.op == OP_DIV_INIT;
    assign div_ctrl.step = uw.op == OP_DIV_STEP;

    always_comb begin
        pc_next      = pc_reg;
        neg_next     = neg_reg;
        radix_next   = radix_reg;
        nd_next      = nd_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (go) begin
            pc_next = cond_true ? uw.target : pc_reg + PC_W'(1);
            case (uw.op)
                OP_ACCEPT: begin
                    neg_next   = in_value[VALUE_WIDTH-1];
                    radix_next = in_radix;
                    nd_next    = '0;
                end
                OP_PUSH: begin
                    nd_next = nd_reg + ND_W'(1);
                end
                OP_EMIT_SIGN: begin
                    m_char_next = CHAR_MINUS;
                    m_last_next = 1'b0;
                end
                OP_EMIT_DIGIT: begin
                    m_char_next = digit_char(digits_reg[nd_m1[IDX_W-1:0]]);
                    m_last_next = 1'b0;
                    nd_next     = nd_m1;
                end
                OP_EMIT_TERM: begin
                    m_char_next = CHAR_NUL;
                    m_last_next = 1'b1;
                end
                default: begin
                end
            endcase
            if (is_emit) begin
                m_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PC_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and digit stack; the stack is written at the count and read just below it.
    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        radix_reg  <= radix_next;
        nd_reg     <= nd_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        if (uw.op == OP_PUSH) begin
            digits_reg[nd_reg[IDX_W-1:0]] <= remainder;
        end
    end

    itora_div u_div (
        .aclk       (aclk),
        .ctrl       (div_ctrl),
        .load_value (in_mag),
        .radix      (radix_reg),
        .quotient   (quotient),
        .remainder  (remainder),
        .more       (div_more)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_last_is_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == CHAR_NUL)
        else $error("terminator carries a non-NUL character");

    a_body_not_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata != CHAR_NUL)
        else $error("NUL character sent before the terminator");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> pc_reg == PC_CHECK)
        else $error("sequencer did not start after an input transfer");

    a_digit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == PC_PUSH |-> remainder < radix_reg)
        else $error("divider remainder not below the radix");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg != PC_IDLE |-> nd_reg <= ND_W'(VALUE_WIDTH))
        else $error("digit stack overflow");
`endif

endmodule

// File: rtl/itora_div.sv
// Bit-serial restoring divider: one quotient bit per step, by a radix of up to six bits.
module itora_div
    import itora_pkg::*;
(
    input  logic                   aclk,
    input  div_ctrl_t              ctrl,
    input  logic [VALUE_WIDTH-1:0] load_value,
    input  logic [RADIX_W-1:0]     radix,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [DIGIT_W-1:0]     remainder,
    output logic                   more
);

    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIGIT_W:0]       trial;
    logic                   fits;

    // The remainder stays below the radix, so the shifted trial fits in seven bits.
    assign trial = {rem_reg, q_reg[VALUE_WIDTH-1]};
    assign fits  = trial >= {1'b0, radix};

    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            q_next = load_value;
        end else if (ctrl.init) begin
            rem_next = '0;
            cnt_next = '0;
        end else if (ctrl.step) begin
            q_next   = {q_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? DIGIT_W'(trial - {1'b0, radix}) : DIGIT_W'(trial);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign quotient  = q_reg;
    assign remainder = rem_reg;
    assign more      = cnt_reg != CNT_W'(VALUE_WIDTH - 1);

endmodule

// File: test/tb_integer_to_radix_ascii_top.sv
// Self-checking testbench for the integer to radix ASCII converter.
module tb_integer_to_radix_ascii_top;
    import itora_pkg::*;

    // One character of the text that the converter sends back, with its end-of-string flag.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    // A directed row either carries its text typed in, or leaves the text to the predictor.
    typedef struct {
        logic [31:0] number;
        logic [5:0]  radix;
        bit          typed;
        string       text;
    } directed_row_t;

    localparam int DIRECTED_ROWS    = 25;
    localparam int PHASES           = 4;
    localparam int RANDOM_PER_PHASE = 36;
    localparam int DRAIN_CYCLES     = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // number[31:0], radix[37:32], zero pad[39:38]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // character[7:0]
    logic        m_tlast;

    // Characters still owed by the converter, oldest first.
    text_char_t expected_chars[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int failures = 0;
    int items_converted = 0;
    int bad_radix_items = 0;
    int chars_checked = 0;
    int text_length = 0;
    int longest_text = 0;

    // Directed rows: zero, both ends of the range, the most negative value in several
    // radices, minus one, the largest digit, the signed radix and radices out of range.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32'd0,          6'd10, 1'b1, "0"},
        '{32'd0,          6'd2,  1'b1, "0"},
        '{32'h7fff_ffff,  6'd10, 1'b1, "2147483647"},
        '{32'h8000_0000,  6'd10, 1'b1, "-2147483648"},
        '{32'h8000_0000,  6'd2,  1'b1, "10000000000000000000000000000000"},
        '{32'h8000_0000,  6'd16, 1'b1, "80000000"},
        '{32'hffff_ffff,  6'd10, 1'b1, "-1"},
        '{32'hffff_ffff,  6'd16, 1'b1, "1"},
        '{32'hffff_ffff,  6'd2,  1'b1, "1"},
        '{32'h7fff_ffff,  6'd2,  1'b0, ""},
        '{32'd35,         6'd36, 1'b1, "z"},
        '{32'd36,         6'd36, 1'b1, "10"},
        '{32'h7fff_ffff,  6'd36, 1'b0, ""},
        '{32'h8000_0000,  6'd36, 1'b0, ""},
        '{32'd255,        6'd16, 1'b1, "ff"},
        '{32'd12345,      6'd8,  1'b0, ""},
        '{-32'sd12345,    6'd16, 1'b0, ""},
        '{32'd5,          6'd0,  1'b1, ""},
        '{32'd5,          6'd1,  1'b1, ""},
        '{-32'sd5,        6'd37, 1'b1, ""},
        '{32'd0,          6'd63, 1'b1, ""},
        '{32'd9,          6'd10, 1'b1, "9"},
        '{32'd10,         6'd11, 1'b1, "a"},
        '{-32'sd100,      6'd3,  1'b0, ""},
        '{32'd1234567890, 6'd35, 1'b0, ""}
    };

    integer_to_radix_ascii_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Works out the text of one number in one radix and queues it, terminator included.
    // Only radix ten shows a sign; other radices print the magnitude, and the most
    // negative value negates onto itself, which read unsigned is exactly its magnitude.
    function automatic void predict_text(input logic [31:0] number, input logic [5:0] radix);
        logic [7:0]  digit_stack [VALUE_WIDTH+2];
        logic [31:0] magnitude;
        logic [31:0] digit;
        logic        negative;
        int          depth;
        depth = 0;
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            expected_chars.push_back(text_char_t'{CHAR_NUL, 1'b1});
            return;
        end
        negative  = number[31];
        magnitude = negative ? (~number + 32'd1) : number;
        do begin
            digit = magnitude % {26'd0, radix};
            digit_stack[depth] = (digit < 32'd10) ? CHAR_ZERO + digit[7:0]
                                                  : CHAR_A + digit[7:0] - 8'd10;
            depth++;
            magnitude = magnitude / {26'd0, radix};
        end while (magnitude != 32'd0);
        if (negative && radix == SIGNED_RADIX) begin
            expected_chars.push_back(text_char_t'{CHAR_MINUS, 1'b0});
        end
        while (depth > 0) begin
            depth--;
            expected_chars.push_back(text_char_t'{digit_stack[depth], 1'b0});
        end
        expected_chars.push_back(text_char_t'{CHAR_NUL, 1'b1});
    endfunction

    function automatic void note_failure(input string msg);
        if (failures < 10) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        failures++;
    endfunction

    // Offers one number for conversion, after a random gap, and holds it until the
    // transfer completes. The expected text is queued at the edge that accepts it.
    task automatic send_number(input logic [31:0] number, input logic [5:0] radix,
                               input bit typed, input string text);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, radix, number};
        do @(posedge aclk); while (!s_tready);
        if (typed) begin
            for (int i = 0; i < text.len(); i++) begin
                expected_chars.push_back(text_char_t'{text[i], 1'b0});
            end
            expected_chars.push_back(text_char_t'{CHAR_NUL, 1'b1});
        end else begin
            predict_text(number, radix);
        end
        items_converted++;
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            bad_radix_items++;
        end
        @(negedge aclk);
    endtask

    // The receiver stalls at random, decided afresh on every falling edge.
    always @(negedge aclk) begin
        m_tready <= (aresetn == 1'b0) ? 1'b1 : ($urandom_range(99) >= receiver_stall_pct);
    end

    // Every character transfer is checked against the oldest character still owed.
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            chars_checked++;
            text_length++;
            if (m_tlast) begin
                if (text_length > longest_text) begin
                    longest_text = text_length;
                end
                text_length = 0;
            end
            if (expected_chars.size() == 0) begin
                note_failure($sformatf("unexpected character 0x%02h, last %0b",
                                       m_tdata, m_tlast));
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.character) begin
                    note_failure($sformatf("character: expected 0x%02h, got 0x%02h",
                                           want.character, m_tdata));
                end
                if (m_tlast !== want.last) begin
                    note_failure($sformatf("last flag: expected %0b, got %0b",
                                           want.last, m_tlast));
                end
            end
        end
    end

    // The slowest correct run has every item a 32-digit binary string, plus stalls;
    // this limit is several times that.
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [31:0] number;
        logic [5:0]  radix;
        int          pick;
        int          shift;

        // Reset is held at the start and released on a falling edge.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 50;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 50;
                end
                default: begin
                    sender_idle_pct = 16;
                    receiver_stall_pct = 16;
                end
            endcase

            if (phase == 0) begin
                foreach (directed_rows[i]) begin
                    send_number(directed_rows[i].number, directed_rows[i].radix,
                                directed_rows[i].typed, directed_rows[i].text);
                end
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Full-width values most often, with small ones, values near a power of
                // two and the range ends mixed in so that short strings come often.
                pick = $urandom_range(99);
                if (pick < 40) begin
                    number = $urandom;
                end else if (pick < 65) begin
                    number = $urandom_range(600) - 300;
                end else if (pick < 80) begin
                    number = $urandom_range(65535);
                    if ($urandom_range(1)) number = -number;
                end else if (pick < 90) begin
                    shift  = $urandom_range(31);
                    number = (32'd1 << shift) - $urandom_range(1);
                    if ($urandom_range(1)) number = -number;
                end else begin
                    case ($urandom_range(4))
                        0:       number = 32'h8000_0000;
                        1:       number = 32'h7fff_ffff;
                        2:       number = 32'hffff_ffff;
                        3:       number = 32'h8000_0001;
                        default: number = 32'd0;
                    endcase
                end

                // Radix ten is favoured for its sign; a few radices are out of range.
                pick = $urandom_range(99);
                if (pick < 8) begin
                    radix = 6'($urandom_range(1) ? $urandom_range(1) : $urandom_range(63, 37));
                end else if (pick < 23) begin
                    radix = SIGNED_RADIX;
                end else begin
                    radix = 6'($urandom_range(RADIX_MAX, RADIX_MIN));
                end
                send_number(number, radix, 1'b0, "");
            end

            // The sender holds off until the converter has returned every owed character.
            s_tvalid = 1'b0;
            while (expected_chars.size() != 0) @(negedge aclk);
        end

        // Any character that turns up during this drain is unexpected.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_chars.size() != 0) begin
            note_failure($sformatf("%0d characters never arrived", expected_chars.size()));
        end

        $display("Converted %0d numbers (%0d with a radix out of range) into %0d characters;",
                 items_converted, bad_radix_items, chars_checked);
        $display("longest string %0d characters, over four idle and stall patterns.",
                 longest_text);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total.", failures);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
